// ----- rtl/iacf_pkg.sv -----
package iacf_pkg;

	localparam int DATA_WIDTH_DEF = 64;
	localparam int Q_DEPTH = 4;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_UDIV = 5'd3;
	localparam logic [4:0] OP_UMOD = 5'd4;
	localparam logic [4:0] OP_SDIV = 5'd5;
	localparam logic [4:0] OP_SMOD = 5'd6;
	localparam logic [4:0] OP_AND  = 5'd7;
	localparam logic [4:0] OP_OR   = 5'd8;
	localparam logic [4:0] OP_XOR  = 5'd9;
	localparam logic [4:0] OP_LSL  = 5'd10;
	localparam logic [4:0] OP_LSR  = 5'd11;
	localparam logic [4:0] OP_ASR  = 5'd12;
	localparam logic [4:0] OP_EQ   = 5'd13;
	localparam logic [4:0] OP_UGT  = 5'd14;
	localparam logic [4:0] OP_UGE  = 5'd15;
	localparam logic [4:0] OP_SGT  = 5'd16;
	localparam logic [4:0] OP_SGE  = 5'd17;
	localparam logic [4:0] OP_NEG  = 5'd18;
	localparam logic [4:0] OP_NOT  = 5'd19;
	localparam logic [4:0] OP_LNOT = 5'd20;

	typedef struct packed {
		logic [4:0] op;
		logic       sh_big;
		logic       dz;
		logic       neg_q;
		logic       neg_r;
	} ctl_t;

endpackage

// ----- rtl/iacf_front.sv -----
module iacf_front
	import iacf_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  in_valid,
	input  logic [4:0]            req_type,
	input  logic [63:0]           operand_a,
	input  logic [63:0]           operand_b,
	input  logic                  q_full,
	output logic                  in_stall,
	output logic                  push,
	output ctl_t                  ctl,
	output logic [DATA_WIDTH-1:0] a,
	output logic [DATA_WIDTH-1:0] b,
	output logic [DATA_WIDTH-1:0] dvd,
	output logic [DATA_WIDTH-1:0] dvs
);

	logic na, nb, is_div, is_sgn;

	assign a = operand_a[DATA_WIDTH-1:0];
	assign b = operand_b[DATA_WIDTH-1:0];
	assign na = a[DATA_WIDTH-1];
	assign nb = b[DATA_WIDTH-1];
	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		is_sgn = (req_type == OP_SDIV) || (req_type == OP_SMOD);
		is_div = (req_type == OP_UDIV) || (req_type == OP_UMOD) || is_sgn;
		ctl.op = req_type;
		ctl.sh_big = operand_b >= 64'(DATA_WIDTH);
		ctl.dz = is_div && (b == '0);
		ctl.neg_q = (req_type == OP_SDIV) && (na != nb);
		ctl.neg_r = (req_type == OP_SMOD) && na;
		dvd = (is_sgn && na) ? -a : a;
		dvs = (is_sgn && nb) ? -b : b;
	end

endmodule

// ----- rtl/iacf_queue.sv -----
module iacf_queue
	import iacf_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ctl_t                  push_ctl,
	input  logic [DATA_WIDTH-1:0] push_a,
	input  logic [DATA_WIDTH-1:0] push_b,
	input  logic [DATA_WIDTH-1:0] push_dvd,
	input  logic [DATA_WIDTH-1:0] push_dvs,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output ctl_t                  head_ctl,
	output logic [DATA_WIDTH-1:0] head_a,
	output logic [DATA_WIDTH-1:0] head_b,
	output logic [DATA_WIDTH-1:0] head_dvd,
	output logic [DATA_WIDTH-1:0] head_dvs
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		ctl_t                  ctl;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		logic [DATA_WIDTH-1:0] dvd;
		logic [DATA_WIDTH-1:0] dvs;
	} ent_t;

	ent_t mem_q [Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_pop;

	assign full = cnt_q == CW'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_pop = pop && not_empty;
	assign head_ctl = mem_q[rd_q].ctl;
	assign head_a = mem_q[rd_q].a;
	assign head_b = mem_q[rd_q].b;
	assign head_dvd = mem_q[rd_q].dvd;
	assign head_dvs = mem_q[rd_q].dvs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{ctl: push_ctl, a: push_a, b: push_b, dvd: push_dvd, dvs: push_dvs};
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Q_DEPTH)) else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into a full queue");
`endif

endmodule

// ----- rtl/iacf_back.sv -----
module iacf_back
	import iacf_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  ctl_t                  q_ctl,
	input  logic [DATA_WIDTH-1:0] q_a,
	input  logic [DATA_WIDTH-1:0] q_b,
	input  logic [DATA_WIDTH-1:0] q_dvd,
	input  logic [DATA_WIDTH-1:0] q_dvs,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           result,
	output logic                  div_zero
);

	localparam int W = DATA_WIDTH;
	localparam int LO = (W + 1) / 2;
	localparam int HI = W - LO;
	localparam int SW = $clog2(W);

	typedef struct packed {
		ctl_t         ctl;
		logic [W-1:0] res;
		logic [W-1:0] p0;
		logic [W-1:0] p1;
		logic [W-1:0] p2;
		logic [W-1:0] rem;
		logic [W-1:0] quo;
		logic [W-1:0] dvs;
	} pipe_t;

	logic         en;
	logic         v_s [W+1];
	pipe_t        d_s [W+1];
	pipe_t        d0;
	logic [2*LO-1:0] pp0;
	logic [SW-1:0]   sa;
	logic [W-1:0]    fin;
	logic [4:0]      op_q;

	assign en = !out_valid || !out_stall;
	assign pop = en;
	assign sa = q_b[SW-1:0];

	always_comb begin
		pp0 = {{LO{1'b0}}, q_a[LO-1:0]} * {{LO{1'b0}}, q_b[LO-1:0]};
		d0 = '0;
		d0.ctl = q_ctl;
		d0.p0 = pp0[W-1:0];
		d0.p1 = {{HI{1'b0}}, q_a[LO-1:0]} * {{LO{1'b0}}, q_b[W-1:LO]};
		d0.p2 = {{LO{1'b0}}, q_a[W-1:LO]} * {{HI{1'b0}}, q_b[LO-1:0]};
		d0.quo = q_dvd;
		d0.dvs = q_dvs;
		case (q_ctl.op)
			OP_ADD:  d0.res = q_a + q_b;
			OP_SUB:  d0.res = q_a - q_b;
			OP_AND:  d0.res = q_a & q_b;
			OP_OR:   d0.res = q_a | q_b;
			OP_XOR:  d0.res = q_a ^ q_b;
			OP_LSL:  d0.res = q_ctl.sh_big ? '0 : q_a << sa;
			OP_LSR:  d0.res = q_ctl.sh_big ? '0 : q_a >> sa;
			OP_ASR:  d0.res = q_ctl.sh_big ? {W{q_a[W-1]}} : W'($signed(q_a) >>> sa);
			OP_EQ:   d0.res = W'(q_a == q_b);
			OP_UGT:  d0.res = W'(q_a > q_b);
			OP_UGE:  d0.res = W'(q_a >= q_b);
			OP_SGT:  d0.res = W'($signed(q_a) > $signed(q_b));
			OP_SGE:  d0.res = W'($signed(q_a) >= $signed(q_b));
			OP_NEG:  d0.res = -q_a;
			OP_NOT:  d0.res = ~q_a;
			OP_LNOT: d0.res = W'(q_a == '0);
			default: d0.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= d0;
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_stage
		logic [W:0] rw;
		logic       ge;
		pipe_t      nx;

		always_comb begin
			nx = d_s[k-1];
			rw = {d_s[k-1].rem, d_s[k-1].quo[W-1]};
			ge = rw >= {1'b0, d_s[k-1].dvs};
			nx.rem = ge ? W'(rw - {1'b0, d_s[k-1].dvs}) : rw[W-1:0];
			nx.quo = {d_s[k-1].quo[W-2:0], ge};
			if (k == 1 && d_s[k-1].ctl.op == OP_MUL) begin
				nx.res = d_s[k-1].p0 + W'((d_s[k-1].p1 + d_s[k-1].p2) << LO);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k] <= nx;
			end
		end
	end

	always_comb begin
		case (d_s[W].ctl.op)
			OP_UDIV: fin = d_s[W].quo;
			OP_UMOD: fin = d_s[W].rem;
			OP_SDIV: fin = d_s[W].ctl.neg_q ? -d_s[W].quo : d_s[W].quo;
			OP_SMOD: fin = d_s[W].ctl.neg_r ? -d_s[W].rem : d_s[W].rem;
			default: fin = d_s[W].res;
		endcase
		if (d_s[W].ctl.dz) begin
			fin = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= 64'($signed(fin));
			div_zero <= d_s[W].ctl.dz;
			op_q <= d_s[W].ctl.op;
		end
	end

`ifndef SYNTHESIS
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_zero) |-> (result == '0)) else $error("divide by zero gave nonzero");
	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_zero) |-> (op_q == OP_UDIV || op_q == OP_UMOD ||
		op_q == OP_SDIV || op_q == OP_SMOD)) else $error("div_zero on a non-divide");
	a_cmp_bool: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (op_q == OP_EQ || op_q == OP_UGT || op_q == OP_SGE ||
		op_q == OP_LNOT)) |-> (result[63:1] == '0)) else $error("compare not 0 or 1");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s[W]) && $stable(result))) else $error("pipeline moved while held");
`endif

endmodule

// ----- rtl/integer_alu_const_folder.sv -----
// Integer evaluator for constant folding: one opcode and two operands per beat, one result
// beat per input beat, in order. A new beat is accepted every cycle while the four-entry
// queue between the decode front and the execution pipeline has room; an accepted beat passes
// through the queue, the operand register and one divider stage per quotient bit to the output
// register; the divider is a restoring one that retires one quotient bit per pipeline stage.
module integer_alu_const_folder
	import iacf_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  req_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result,
	output logic        div_zero
);

	logic                  push, q_full, q_ne, pop;
	ctl_t                  f_ctl, h_ctl;
	logic [DATA_WIDTH-1:0] f_a, f_b, f_dvd, f_dvs, h_a, h_b, h_dvd, h_dvs;

	iacf_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.in_valid(in_valid), .req_type(req_type), .operand_a(operand_a),
		.operand_b(operand_b), .q_full(q_full), .in_stall(in_stall), .push(push),
		.ctl(f_ctl), .a(f_a), .b(f_b), .dvd(f_dvd), .dvs(f_dvs)
	);

	iacf_queue #(.DATA_WIDTH(DATA_WIDTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_ctl(f_ctl), .push_a(f_a),
		.push_b(f_b), .push_dvd(f_dvd), .push_dvs(f_dvs), .pop(pop), .full(q_full),
		.not_empty(q_ne), .head_ctl(h_ctl), .head_a(h_a), .head_b(h_b),
		.head_dvd(h_dvd), .head_dvs(h_dvs)
	);

	iacf_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_not_empty(q_ne), .q_ctl(h_ctl), .q_a(h_a),
		.q_b(h_b), .q_dvd(h_dvd), .q_dvs(h_dvs), .pop(pop), .out_valid(out_valid),
		.out_stall(out_stall), .result(result), .div_zero(div_zero)
	);

endmodule

// ----- tb/integer_alu_const_folder_test.sv -----
`timescale 1ns / 1ps

module integer_alu_const_folder_test
	import iacf_pkg::*;
();

	localparam int LATENCY = 64 + 2;
	localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

	typedef struct {
		logic [63:0] result;
		logic        div_zero;
	} alu_out_t;

	typedef struct {
		logic [4:0]  op;
		logic [63:0] a;
		logic [63:0] b;
		logic        known;
		logic [63:0] result;
		logic        div_zero;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [4:0]  req_type = '0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result;
	logic        div_zero;

	alu_out_t pending_results[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int dz_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	integer_alu_const_folder i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall), .result(result),
		.div_zero(div_zero)
	);

	always #5 clk = ~clk;

	function automatic alu_out_t evaluate(logic [4:0] op, logic [63:0] a, logic [63:0] b);
		alu_out_t o;
		logic [63:0] ma, mb, q;
		o.result = '0;
		o.div_zero = 1'b0;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		case (op)
			OP_ADD: o.result = a + b;
			OP_SUB: o.result = a - b;
			OP_MUL: o.result = a * b;
			OP_UDIV, OP_UMOD, OP_SDIV, OP_SMOD: begin
				if (b == '0) begin
					o.div_zero = 1'b1;
				end else if (op == OP_UDIV) begin
					o.result = a / b;
				end else if (op == OP_UMOD) begin
					o.result = a % b;
				end else if (op == OP_SDIV) begin
					q = ma / mb;
					o.result = (a[63] != b[63]) ? -q : q;
				end else begin
					q = ma % mb;
					o.result = a[63] ? -q : q;
				end
			end
			OP_AND: o.result = a & b;
			OP_OR:  o.result = a | b;
			OP_XOR: o.result = a ^ b;
			OP_LSL: o.result = (b >= 64) ? '0 : a << b[5:0];
			OP_LSR: o.result = (b >= 64) ? '0 : a >> b[5:0];
			OP_ASR: o.result = (b >= 64) ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
			OP_EQ:  o.result = {63'b0, a == b};
			OP_UGT: o.result = {63'b0, a > b};
			OP_UGE: o.result = {63'b0, a >= b};
			OP_SGT: o.result = {63'b0, $signed(a) > $signed(b)};
			OP_SGE: o.result = {63'b0, $signed(a) >= $signed(b)};
			OP_NEG: o.result = -a;
			OP_NOT: o.result = ~a;
			OP_LNOT: o.result = {63'b0, a == '0};
			default: o.result = '0;
		endcase
		return o;
	endfunction

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: v = MIN_S;
			1: v = MAX_S;
			2: v = ONES;
			3: v = '0;
			4: v = 64'($urandom_range(0, 70));
			5: v = -64'($urandom_range(0, 70));
			default: ;
		endcase
		return v;
	endfunction

	task automatic send(logic [4:0] op, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(evaluate(op, a, b));
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		alu_out_t exp_out;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: %h", $time, result);
				errors++;
			end else begin
				exp_out = pending_results.pop_front();
				if (div_zero) dz_seen++;
				if (result !== exp_out.result) begin
					$display("%0t: result expected %h actual %h", $time,
						exp_out.result, result);
					errors++;
				end
				if (div_zero !== exp_out.div_zero) begin
					$display("%0t: div_zero expected %b actual %b", $time,
						exp_out.div_zero, div_zero);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		vector_t directed[$];
		alu_out_t calc;
		int phase;
		directed = '{
			'{OP_ADD,  MAX_S, 64'd1, 1'b1, MIN_S, 1'b0},
			'{OP_SUB,  MIN_S, 64'd1, 1'b1, MAX_S, 1'b0},
			'{OP_MUL,  MIN_S, ONES, 1'b1, MIN_S, 1'b0},
			'{OP_UDIV, ONES, 64'd0, 1'b1, 64'd0, 1'b1},
			'{OP_UMOD, ONES, 64'd0, 1'b1, 64'd0, 1'b1},
			'{OP_SDIV, MIN_S, 64'd0, 1'b1, 64'd0, 1'b1},
			'{OP_SMOD, 64'd5, 64'd0, 1'b1, 64'd0, 1'b1},
			'{OP_SDIV, MIN_S, ONES, 1'b1, MIN_S, 1'b0},
			'{OP_SMOD, MIN_S, ONES, 1'b1, 64'd0, 1'b0},
			'{OP_SDIV, -64'd7, 64'd2, 1'b1, -64'd3, 1'b0},
			'{OP_SMOD, -64'd7, 64'd2, 1'b1, ONES, 1'b0},
			'{OP_UDIV, ONES, 64'd3, 1'b0, 64'd0, 1'b0},
			'{OP_AND,  ONES, MAX_S, 1'b1, MAX_S, 1'b0},
			'{OP_OR,   MIN_S, 64'd1, 1'b1, MIN_S | 64'd1, 1'b0},
			'{OP_XOR,  ONES, ONES, 1'b1, 64'd0, 1'b0},
			'{OP_LSL,  ONES, 64'd64, 1'b1, 64'd0, 1'b0},
			'{OP_LSR,  ONES, ONES, 1'b1, 64'd0, 1'b0},
			'{OP_ASR,  MIN_S, 64'd64, 1'b1, ONES, 1'b0},
			'{OP_ASR,  MIN_S, 64'd63, 1'b1, ONES, 1'b0},
			'{OP_EQ,   ONES, ONES, 1'b1, 64'd1, 1'b0},
			'{OP_UGT,  ONES, MAX_S, 1'b1, 64'd1, 1'b0},
			'{OP_UGE,  64'd0, 64'd0, 1'b1, 64'd1, 1'b0},
			'{OP_SGT,  ONES, MAX_S, 1'b1, 64'd0, 1'b0},
			'{OP_SGE,  MIN_S, MIN_S, 1'b1, 64'd1, 1'b0},
			'{OP_NEG,  MIN_S, ONES, 1'b1, MIN_S, 1'b0},
			'{OP_NOT,  64'd0, ONES, 1'b1, ONES, 1'b0},
			'{OP_LNOT, 64'd0, ONES, 1'b1, 64'd1, 1'b0},
			'{5'd31,   ONES, ONES, 1'b1, 64'd0, 1'b0}
		};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			calc = evaluate(directed[i].op, directed[i].a, directed[i].b);
			if (directed[i].known && (calc.result !== directed[i].result
					|| calc.div_zero !== directed[i].div_zero)) begin
				$display("%0t: table row %0d expected %h/%b predictor %h/%b", $time, i,
					directed[i].result, directed[i].div_zero, calc.result, calc.div_zero);
				errors++;
			end
			send(directed[i].op, directed[i].a, directed[i].b);
		end
		drain();

		// A long receiver hold while beats keep coming fills the pipeline.
		hold_cycles <= 300;
		for (int i = 0; i < 100; i++)
			send(5'($urandom_range(0, 31)), rand_operand(), rand_operand());
		drain();

		for (int n = 0; n < 1600; n++) begin
			phase = n / 200;
			send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 85 : 0;
			recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? 85 : 0;
			if (phase % 4 == 3) begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
			send(($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
				: 5'($urandom_range(0, 20)), rand_operand(), rand_operand());
			if (n == 800) drain();
		end
		drain();
		repeat (LATENCY * 2) @(negedge clk);

		$display("Sent %0d beats, received %0d, %0d of them with a zero divisor.",
			beats_in, beats_out, dz_seen);
		$display("All opcodes, operand extremes and four handshake idling mixes were run.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
